>>> hw/rtl/pfhe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfhe_pkg
// Shared types and constants of the IPv4 flow header extractor.
// ----------------------------------------------------------------------------
package pfhe_pkg;

    localparam logic [15:0] ETH_LEN       = 16'd14;
    localparam logic [15:0] IP_MIN_LEN    = 16'd20;
    localparam logic [15:0] ETHERTYPE_V4  = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [7:0]  IHL_MASK      = 8'h0F;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // frame byte offsets of header fields, OFS_FLAGS from layer-4 start
    localparam logic [15:0] OFS_TYPE_HI   = 16'd12;
    localparam logic [15:0] OFS_TYPE_LO   = 16'd13;
    localparam logic [15:0] OFS_VIHL      = 16'd14;
    localparam logic [15:0] OFS_TLEN_HI   = 16'd16;
    localparam logic [15:0] OFS_TLEN_LO   = 16'd17;
    localparam logic [15:0] OFS_FFO_HI    = 16'd20;
    localparam logic [15:0] OFS_FFO_LO    = 16'd21;
    localparam logic [15:0] OFS_PROTO     = 16'd23;
    localparam logic [15:0] OFS_SRC       = 16'd26;
    localparam logic [15:0] OFS_DST       = 16'd30;
    localparam logic [15:0] OFS_FLAGS     = 16'd13;

    typedef enum logic [2:0] {
        ST_PASS       = 3'd0,
        ST_BEFORE     = 3'd1,
        ST_AFTER      = 3'd2,
        ST_SHORT      = 3'd3,
        ST_NOTV4      = 3'd4,
        ST_FRAG       = 3'd5,
        ST_NZFRAG     = 3'd6,
        ST_INCOMPLETE = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CFG_BEGIN_SEC   = 3'd0,
        CFG_BEGIN_USEC  = 3'd1,
        CFG_END_SEC     = 3'd2,
        CFG_END_USEC    = 3'd3,
        CFG_REJ_ALL     = 3'd4,
        CFG_REJ_NZ      = 3'd5,
        CFG_REJ_INC     = 3'd6
    } cfg_idx_t;

    // header fields of one finished frame, handed from front to back
    typedef struct packed {
        logic [15:0] caplen;
        logic [15:0] ethertype;
        logic [7:0]  vihl;
        logic [15:0] tlen;
        logic [15:0] ffo;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] l4_w0;
        logic [15:0] l4_w1;
        logic [7:0]  flags;
        logic [31:0] sec;
        logic [19:0] usec;
    } frame_sum_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] total_length;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [31:0] start_sec;
        logic [19:0] start_usec;
        logic        incomplete;
        logic        fragmented;
    } flow_rec_t;

endpackage
`default_nettype wire

>>> hw/rtl/pfhe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfhe_front
// Byte front end: counts frame bytes and latches header fields in flight.
// ----------------------------------------------------------------------------
module pfhe_front
    import pfhe_pkg::*;
#(
    parameter int HEADER_BYTES = 88
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_packet,
    input  wire logic        end_of_packet,
    input  wire logic [31:0] stamp_sec,
    input  wire logic [19:0] stamp_usec,
    output frame_sum_t       sum,
    output logic             sum_push
);

    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] sec_reg, sec_next;
    logic [19:0] usec_reg, usec_next;
    logic [6:0]  l4_reg, l4_next;
    frame_sum_t  f_reg, f_next;
    logic [15:0] idx;
    logic [15:0] l4w;
    logic [7:0]  b;

    always_comb begin
        idx       = start_of_packet ? 16'd0 : cnt_reg;
        b         = (idx < 16'(HEADER_BYTES)) ? data_byte : 8'd0;
        sec_next  = start_of_packet ? stamp_sec : sec_reg;
        usec_next = start_of_packet ? stamp_usec : usec_reg;
        l4_next   = (idx == OFS_VIHL) ? 7'(7'd14 + {1'b0, data_byte[3:0], 2'b00}) : l4_reg;
        l4w       = {9'd0, l4_next};
        f_next    = f_reg;
        if (idx == OFS_TYPE_HI) f_next.ethertype[15:8] = b;
        if (idx == OFS_TYPE_LO) f_next.ethertype[7:0]  = b;
        if (idx == OFS_VIHL)    f_next.vihl            = b;
        if (idx == OFS_TLEN_HI) f_next.tlen[15:8]      = b;
        if (idx == OFS_TLEN_LO) f_next.tlen[7:0]       = b;
        if (idx == OFS_FFO_HI)  f_next.ffo[15:8]       = b;
        if (idx == OFS_FFO_LO)  f_next.ffo[7:0]        = b;
        if (idx == OFS_PROTO)   f_next.proto           = b;
        if (idx == OFS_SRC)           f_next.src[31:24] = b;
        if (idx == OFS_SRC + 16'd1)   f_next.src[23:16] = b;
        if (idx == OFS_SRC + 16'd2)   f_next.src[15:8]  = b;
        if (idx == OFS_SRC + 16'd3)   f_next.src[7:0]   = b;
        if (idx == OFS_DST)           f_next.dst[31:24] = b;
        if (idx == OFS_DST + 16'd1)   f_next.dst[23:16] = b;
        if (idx == OFS_DST + 16'd2)   f_next.dst[15:8]  = b;
        if (idx == OFS_DST + 16'd3)   f_next.dst[7:0]   = b;
        // layer-4 words sit at a position set by this frame's IHL
        if (idx == l4w)               f_next.l4_w0[15:8] = b;
        if (idx == l4w + 16'd1)       f_next.l4_w0[7:0]  = b;
        if (idx == l4w + 16'd2)       f_next.l4_w1[15:8] = b;
        if (idx == l4w + 16'd3)       f_next.l4_w1[7:0]  = b;
        if (idx == l4w + OFS_FLAGS)   f_next.flags       = b;
        f_next.caplen = (idx == COUNT_MAX) ? COUNT_MAX : idx + 16'd1;
        f_next.sec    = sec_next;
        f_next.usec   = usec_next;
        cnt_next      = end_of_packet ? 16'd0 : f_next.caplen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sec_reg  <= '0;
            usec_reg <= '0;
        end else if (in_fire) begin
            cnt_reg  <= cnt_next;
            sec_reg  <= sec_next;
            usec_reg <= usec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            l4_reg <= l4_next;
            f_reg  <= f_next;
        end
    end

    assign sum      = f_next;
    assign sum_push = in_fire && end_of_packet;

endmodule
`default_nettype wire

>>> hw/rtl/pfhe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfhe_queue
// Two-entry queue of frame summaries between front and back.
// ----------------------------------------------------------------------------
module pfhe_queue
    import pfhe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire frame_sum_t push_data,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output frame_sum_t      head
);

    frame_sum_t  mem [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
    end

    assign full       = cnt_reg[1];
    assign head_valid = cnt_reg != 2'd0;
    assign head       = mem[rd_reg];

endmodule
`default_nettype wire

>>> hw/rtl/pfhe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfhe_back
// Classifies one frame summary into a flow record; holds the config.
// ----------------------------------------------------------------------------
module pfhe_back
    import pfhe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire frame_sum_t  sum,
    input  wire logic        sum_valid,
    output logic             sum_pop,
    output flow_rec_t        rec,
    output logic             rec_valid,
    input  wire logic        rec_ready
);

    logic [31:0] bsec_reg, esec_reg;
    logic [19:0] busec_reg, eusec_reg;
    logic        rall_reg, rnz_reg, rinc_reg;
    flow_rec_t   rec_reg, r;
    logic        vld_reg;
    logic [15:0] len_ip, len4, ihl_len;
    logic        have_l4, frag, nzfo, inc, win;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsec_reg  <= '0;
            busec_reg <= '0;
            esec_reg  <= '0;
            eusec_reg <= '0;
            rall_reg  <= 1'b0;
            rnz_reg   <= 1'b0;
            rinc_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BEGIN_SEC:  bsec_reg  <= cfg_wdata;
                CFG_BEGIN_USEC: busec_reg <= cfg_wdata[19:0];
                CFG_END_SEC:    esec_reg  <= cfg_wdata;
                CFG_END_USEC:   eusec_reg <= cfg_wdata[19:0];
                CFG_REJ_ALL:    rall_reg  <= cfg_wdata[0];
                CFG_REJ_NZ:     rnz_reg   <= cfg_wdata[0];
                CFG_REJ_INC:    rinc_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        win     = esec_reg != 32'd0;
        len_ip  = sum.caplen - ETH_LEN;
        ihl_len = {10'd0, sum.vihl[3:0] & IHL_MASK[3:0], 2'b00};
        have_l4 = len_ip > ihl_len;
        len4    = len_ip - ihl_len;
        frag    = sum.ffo[13:0] != 14'd0;
        nzfo    = sum.ffo[12:0] != 13'd0;
        inc     = 1'b0;
        r       = '0;
        r.start_sec  = sum.sec;
        r.start_usec = sum.usec;
        priority if (win && (sum.sec < bsec_reg ||
                     (sum.sec == bsec_reg && sum.usec < busec_reg))) begin
            r.status = ST_BEFORE;
        end else if (win && (sum.sec > esec_reg ||
                     (sum.sec == esec_reg && sum.usec > eusec_reg))) begin
            r.status = ST_AFTER;
        end else if (sum.caplen < ETH_LEN) begin
            r.status = ST_SHORT;
        end else if (sum.ethertype != ETHERTYPE_V4) begin
            r.status = ST_NOTV4;
        end else if (len_ip < IP_MIN_LEN) begin
            r.status = ST_SHORT;
        end else if (sum.vihl[7:4] != IP_VERSION_4) begin
            r.status = ST_NOTV4;
        end else if (frag && rall_reg) begin
            r.status     = ST_FRAG;
            r.fragmented = 1'b1;
        end else if (frag && nzfo && rnz_reg) begin
            r.status     = ST_NZFRAG;
            r.fragmented = 1'b1;
        end else begin
            r.status       = ST_PASS;
            r.fragmented   = frag;
            r.src_addr     = sum.src;
            r.dst_addr     = sum.dst;
            r.protocol     = sum.proto;
            r.total_length = sum.tlen;
            if (have_l4 && !nzfo) begin
                if (sum.proto == PROTO_ICMP) begin
                    // type and code land in the destination port
                    if (len4 < 16'd2) inc = 1'b1;
                    else r.dst_port = sum.l4_w0;
                end else if (sum.proto == PROTO_TCP) begin
                    if (len4 < 16'd14) inc = 1'b1;
                    else r.tcp_flags = sum.flags;
                    if (len4 >= 16'd4) begin
                        r.src_port = sum.l4_w0;
                        r.dst_port = sum.l4_w1;
                    end
                end else if (sum.proto == PROTO_UDP) begin
                    if (len4 < 16'd4) inc = 1'b1;
                    else begin
                        r.src_port = sum.l4_w0;
                        r.dst_port = sum.l4_w1;
                    end
                end
            end
            r.incomplete = inc;
            if (inc && rinc_reg) begin
                r            = '0;
                r.status     = ST_INCOMPLETE;
                r.incomplete = 1'b1;
                r.start_sec  = sum.sec;
                r.start_usec = sum.usec;
            end
        end
    end

    assign sum_pop = sum_valid && (!vld_reg || rec_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (sum_pop) begin
            vld_reg <= 1'b1;
        end else if (rec_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_pop) rec_reg <= r;
    end

    assign rec       = rec_reg;
    assign rec_valid = vld_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ipv4_packet_flow_header_extractor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Frame summaries pass through the queue into the record register. One byte
// is taken per cycle while the queue has room; a one-byte frame may follow any
// frame; the classifier finishes one summary per cycle unless m_tready stalls.
// Reset: aresetn clears the byte count, time stamp, config and the queue;
// the latched header fields need no reset since every one read is rewritten.
// ----------------------------------------------------------------------------
// ipv4_packet_flow_header_extractor_unit
// Parses Ethernet/IPv4/L4 headers from a byte stream into flow records.
// ----------------------------------------------------------------------------
module ipv4_packet_flow_header_extractor_unit
    import pfhe_pkg::*;
#(
    parameter int HEADER_BYTES = 88
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write port
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    // byte input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // data_byte, stamp_sec, stamp_usec
    input  wire logic         s_tlast,   // end_of_packet
    input  wire logic [0:0]   s_tuser,   // start_of_packet
    // flow records
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, src_addr, dst_addr, protocol, total_length, src_port,
    // dst_port, tcp_flags, start_sec, start_usec, incomplete, fragmented
    output logic [191:0]      m_tdata
);

    frame_sum_t sum_in, sum_head;
    flow_rec_t  rec;
    logic       in_fire, push, full, head_valid, pop;

    // accept bytes while the queue has room; m_tready paces its draining
    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    pfhe_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_fire         (in_fire),
        .data_byte       (s_tdata[7:0]),
        .start_of_packet (s_tuser[0]),
        .end_of_packet   (s_tlast),
        .stamp_sec       (s_tdata[39:8]),
        .stamp_usec      (s_tdata[59:40]),
        .sum             (sum_in),
        .sum_push        (push)
    );

    pfhe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (sum_in),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (sum_head)
    );

    pfhe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sum       (sum_head),
        .sum_valid (head_valid),
        .sum_pop   (pop),
        .rec       (rec),
        .rec_valid (m_tvalid),
        .rec_ready (m_tready)
    );

    // pack the record, first field in the lowest bits
    assign m_tdata = {7'd0, rec.fragmented, rec.incomplete, rec.start_usec,
                      rec.start_sec, rec.tcp_flags, rec.dst_port, rec.src_port,
                      rec.total_length, rec.protocol, rec.dst_addr,
                      rec.src_addr, rec.status};

endmodule
`default_nettype wire

>>> tb/flow_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_record_checker
// Watches the byte and record channels of the flow header extractor, keeps
// its own copy of the parser state and compares every record field by field.
// ----------------------------------------------------------------------------
module flow_record_checker
    import pfhe_pkg::*;
#(
    parameter int HEADER_BYTES = 88
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [63:0]  s_tdata,
    input  wire logic         s_tlast,
    input  wire logic [0:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [191:0] m_tdata,
    output int                fail_count,
    output int                pending,
    output int                records_seen
);

    logic [7:0]  hdr [HEADER_BYTES];
    logic [15:0] nbytes;
    logic [31:0] pkt_sec;
    logic [19:0] pkt_usec;

    logic [31:0] win_begin_sec, win_end_sec;
    logic [19:0] win_begin_usec, win_end_usec;
    logic        rej_all, rej_nz, rej_inc;

    flow_rec_t   expected_records [$];

    function automatic int unsigned hbyte(int unsigned i);
        return (i < HEADER_BYTES) ? int'(hdr[i]) : 0;
    endfunction

    function automatic int unsigned hword(int unsigned i);
        return (hbyte(i) << 8) | hbyte(i + 1);
    endfunction

    // advance the parser by one byte; queue a record on the frame's last byte
    task automatic parse_byte(input logic [7:0] b, input logic sop, input logic eop,
                              input logic [31:0] sec, input logic [19:0] usec);
        flow_rec_t   r;
        status_t     st;
        int unsigned cap, len, ihl, l4, ffo;
        logic        inc, frag, have;
        if (sop) begin
            nbytes   = '0;
            pkt_sec  = sec;
            pkt_usec = usec;
        end
        if (nbytes < HEADER_BYTES) hdr[nbytes] = b;
        if (nbytes != COUNT_MAX) nbytes = nbytes + 16'd1;
        if (!eop) return;

        cap    = nbytes;
        nbytes = '0;
        r      = '0;
        st     = ST_PASS;
        inc    = 1'b0;
        frag   = 1'b0;
        have   = 1'b0;
        l4     = 0;
        len    = 0;
        if (win_end_sec != 0 && (pkt_sec < win_begin_sec ||
                (pkt_sec == win_begin_sec && pkt_usec < win_begin_usec)))
            st = ST_BEFORE;
        else if (win_end_sec != 0 && (pkt_sec > win_end_sec ||
                (pkt_sec == win_end_sec && pkt_usec > win_end_usec)))
            st = ST_AFTER;
        else if (cap < 14)
            st = ST_SHORT;
        else if (hword(12) != 16'h0800)
            st = ST_NOTV4;
        else if (cap - 14 < 20)
            st = ST_SHORT;
        else if ((hbyte(14) >> 4) != 4)
            st = ST_NOTV4;
        else begin
            len = cap - 14;
            ihl = (hbyte(14) & 'h0F) << 2;
            if (len > ihl) begin
                have = 1'b1;
                l4   = 14 + ihl;
                len  = len - ihl;
            end
            ffo = hword(20);
            if (ffo & 'h3FFF) begin
                frag = 1'b1;
                if (rej_all) st = ST_FRAG;
                else if ((ffo & 'h1FFF) != 0 && rej_nz) st = ST_NZFRAG;
            end
            if (st == ST_PASS) begin
                r.src_addr     = (hword(26) << 16) | hword(28);
                r.dst_addr     = (hword(30) << 16) | hword(32);
                r.protocol     = hbyte(23);
                r.total_length = hword(16);
                if (have && (ffo & 'h1FFF) == 0) begin
                    if (r.protocol == PROTO_ICMP) begin
                        if (len < 2) inc = 1'b1;
                        else r.dst_port = hword(l4);
                    end else if (r.protocol == PROTO_TCP) begin
                        if (len >= 4) begin
                            r.src_port = hword(l4);
                            r.dst_port = hword(l4 + 2);
                        end
                        if (len < 14) inc = 1'b1;
                        else r.tcp_flags = hbyte(l4 + 13);
                    end else if (r.protocol == PROTO_UDP) begin
                        if (len < 4) inc = 1'b1;
                        else begin
                            r.src_port = hword(l4);
                            r.dst_port = hword(l4 + 2);
                        end
                    end
                    if (inc && rej_inc) st = ST_INCOMPLETE;
                end
            end
        end
        // rejected frames carry only the time stamp and their own flag
        if (st != ST_PASS) begin
            r    = '0;
            frag = (st == ST_FRAG || st == ST_NZFRAG);
            inc  = (st == ST_INCOMPLETE);
        end
        r.status     = st;
        r.start_sec  = pkt_sec;
        r.start_usec = pkt_usec;
        r.incomplete = inc;
        r.fragmented = frag;
        expected_records.push_back(r);
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            if (fail_count < 10)
                $display("mismatch in record %0d, %s: expected %h, got %h",
                         records_seen, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count   = 0;
        records_seen = 0;
        pending      = 0;
        nbytes       = '0;
        pkt_sec      = '0;
        pkt_usec     = '0;
        foreach (hdr[i]) hdr[i] = '0;
    end

    always @(posedge aclk) begin
        flow_rec_t e;
        if (!aresetn) begin
            win_begin_sec  <= '0;
            win_begin_usec <= '0;
            win_end_sec    <= '0;
            win_end_usec   <= '0;
            rej_all        <= 1'b0;
            rej_nz         <= 1'b0;
            rej_inc        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_BEGIN_SEC:  win_begin_sec  = cfg_wdata;
                    CFG_BEGIN_USEC: win_begin_usec = cfg_wdata[19:0];
                    CFG_END_SEC:    win_end_sec    = cfg_wdata;
                    CFG_END_USEC:   win_end_usec   = cfg_wdata[19:0];
                    CFG_REJ_ALL:    rej_all        = cfg_wdata[0];
                    CFG_REJ_NZ:     rej_nz         = cfg_wdata[0];
                    CFG_REJ_INC:    rej_inc        = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata[7:0], s_tuser[0], s_tlast, s_tdata[39:8], s_tdata[59:40]);
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    if (fail_count < 10) $display("record %0d arrived unexpected", records_seen);
                    fail_count++;
                end else begin
                    e = expected_records.pop_front();
                    check_field("status",       e.status,       m_tdata[2:0]);
                    check_field("src_addr",     e.src_addr,     m_tdata[34:3]);
                    check_field("dst_addr",     e.dst_addr,     m_tdata[66:35]);
                    check_field("protocol",     e.protocol,     m_tdata[74:67]);
                    check_field("total_length", e.total_length, m_tdata[90:75]);
                    check_field("src_port",     e.src_port,     m_tdata[106:91]);
                    check_field("dst_port",     e.dst_port,     m_tdata[122:107]);
                    check_field("tcp_flags",    e.tcp_flags,    m_tdata[130:123]);
                    check_field("start_sec",    e.start_sec,    m_tdata[162:131]);
                    check_field("start_usec",   e.start_usec,   m_tdata[182:163]);
                    check_field("incomplete",   e.incomplete,   m_tdata[183]);
                    check_field("fragmented",   e.fragmented,   m_tdata[184]);
                end
                records_seen++;
            end
            pending = expected_records.size();
        end
    end

endmodule

>>> tb/tb_ipv4_packet_flow_header_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_packet_flow_header_extractor_unit
// Feeds directed and random Ethernet frames byte by byte through the flow
// header extractor under several window and reject settings, with random
// idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_ipv4_packet_flow_header_extractor_unit;
    import pfhe_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;    // data_byte, stamp_sec, stamp_usec
    logic         s_tlast;    // end_of_packet
    logic [0:0]   s_tuser;    // start_of_packet
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // status, src_addr, dst_addr, protocol, total_length,
                              // src_port, dst_port, tcp_flags, start_sec,
                              // start_usec, incomplete, fragmented
    int           fail_count, pending, records_seen;

    // shared with the record sink: calm disables idling, squeeze starts a hold-off
    logic         calm;
    logic         squeeze;
    int           cycles;
    int           bytes_sent;
    int           frames_sent;

    // window settings of the current phase, used to aim time stamps at the edges
    logic [31:0]  w_begin_sec, w_end_sec;
    logic [19:0]  w_begin_usec, w_end_usec;

    logic [7:0]   frame_bytes [$];

    ipv4_packet_flow_header_extractor_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    flow_record_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .records_seen(records_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog: end the run if it hangs
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // record sink: random stalls, one long hold-off on each squeeze request
    initial begin
        int   hold;
        logic squeeze_seen;
        hold         = 0;
        squeeze_seen = 1'b0;
        m_tready     = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (squeeze && !squeeze_seen) hold = 400;
            squeeze_seen = squeeze;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 18);
            end
            @(posedge aclk);
        end
    end

    // offer one item, idling at random first, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic sop, input logic eop,
                             input logic [31:0] sec, input logic [19:0] usec);
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, usec, sec, b};
        s_tlast  <= eop;
        s_tuser  <= sop;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // send frame_bytes; only the first byte carries the stamp that counts
    task automatic send_frame(input logic with_sop, input logic [31:0] sec,
                              input logic [19:0] usec);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (i == 0)
                send_byte(frame_bytes[i], with_sop, frame_bytes.size() == 1, sec, usec);
            else
                send_byte(frame_bytes[i], 1'b0, i == frame_bytes.size() - 1,
                          $urandom, $urandom_range(999999));
        end
        frames_sent++;
    endtask

    // fill frame_bytes with cap random bytes, then place the header fields
    task automatic build_frame(input int cap, input logic [15:0] etype, input logic [7:0] vihl,
                               input logic [15:0] ffo, input logic [7:0] proto);
        frame_bytes.delete();
        for (int i = 0; i < cap; i++) frame_bytes.push_back($urandom_range(255));
        if (cap > 12) frame_bytes[12] = etype[15:8];
        if (cap > 13) frame_bytes[13] = etype[7:0];
        if (cap > 14) frame_bytes[14] = vihl;
        if (cap > 20) frame_bytes[20] = ffo[15:8];
        if (cap > 21) frame_bytes[21] = ffo[7:0];
        if (cap > 23) frame_bytes[23] = proto;
    endtask

    // aim the stamp at a window edge most of the time
    function automatic logic [31:0] pick_sec();
        case ($urandom_range(6))
            0: return w_begin_sec - 1;
            1: return w_begin_sec;
            2: return w_end_sec;
            3: return w_end_sec + 1;
            4: return w_begin_sec + 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [19:0] pick_usec();
        case ($urandom_range(5))
            0: return w_begin_usec;
            1: return w_end_usec;
            2: return 20'd0;
            3: return 20'd999999;
            default: return $urandom_range(999999);
        endcase
    endfunction

    task automatic random_frame();
        int          kind, ihl, cap, l4_len;
        logic [7:0]  proto;
        logic [15:0] ffo;
        logic        with_sop;
        kind     = $urandom_range(99);
        with_sop = ($urandom_range(99) >= 3);
        ihl      = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
        case ($urandom_range(4))
            0: proto = PROTO_ICMP;
            1, 2: proto = PROTO_TCP;
            3: proto = PROTO_UDP;
            default: proto = $urandom_range(255);
        endcase
        ffo    = ($urandom_range(9) < 7) ? 16'h0000 :
                 (($urandom_range(1) == 1) ? 16'h2000 : 16'($urandom));
        l4_len = ($urandom_range(9) < 8) ? $urandom_range(20) : $urandom_range(80);
        cap    = 14 + ihl * 4 + l4_len;
        if ($urandom_range(9) == 0) cap = 14 + $urandom_range(ihl * 4 + 4);
        if (cap < 34) cap = 34 + $urandom_range(6);
        if (kind < 5)
            build_frame(1, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        else if (kind < 12)
            build_frame($urandom_range(2, 33), ($urandom_range(1) == 1) ? 16'h0800 : 16'($urandom),
                        8'h45, 16'h0, proto);
        else if (kind < 17)
            build_frame(cap, 16'($urandom), 8'h45, ffo, proto);
        else if (kind < 22)
            build_frame(cap, 16'h0800, 8'($urandom), ffo, proto);
        else
            build_frame(cap, 16'h0800, {4'd4, 4'(ihl)}, ffo, proto);
        // sometimes restart a frame in the middle with a fresh start mark
        if ($urandom_range(99) < 3) begin
            for (int i = 0; i < 5; i++)
                send_byte($urandom_range(255), i == 0, 1'b0, $urandom, $urandom_range(999999));
            with_sop = 1'b1;
        end
        send_frame(with_sop, pick_sec(), pick_usec());
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // wait for the pipe to drain, then load all seven registers
    task automatic configure(input logic [31:0] bs, input logic [19:0] bu,
                             input logic [31:0] es, input logic [19:0] eu,
                             input logic ra, input logic rn, input logic ri);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (8) @(posedge aclk);
        write_reg(CFG_BEGIN_SEC, bs);
        write_reg(CFG_BEGIN_USEC, {12'b0, bu});
        write_reg(CFG_END_SEC, es);
        write_reg(CFG_END_USEC, {12'b0, eu});
        write_reg(CFG_REJ_ALL, {31'b0, ra});
        write_reg(CFG_REJ_NZ, {31'b0, rn});
        write_reg(CFG_REJ_INC, {31'b0, ri});
        cfg_we       <= 1'b0;
        w_begin_sec  = bs;
        w_begin_usec = bu;
        w_end_sec    = es;
        w_end_usec   = eu;
    endtask

    task automatic directed_frames();
        // one-byte frame with both marks, then a short frame
        build_frame(1, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd0, 20'd0);
        build_frame(10, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'hFFFFFFFF, 20'd999999);
        // not IPv4 by ethertype, then by version
        build_frame(40, 16'h86DD, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd5, 20'd1);
        build_frame(40, 16'h0800, 8'h65, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd5, 20'd2);
        // ICMP full and cut, TCP full, ports only and cut, UDP full and cut
        build_frame(42, 16'h0800, 8'h45, 16'h0, PROTO_ICMP);
        send_frame(1'b1, 32'd6, 20'd3);
        build_frame(35, 16'h0800, 8'h45, 16'h0, PROTO_ICMP);
        send_frame(1'b1, 32'd6, 20'd4);
        build_frame(54, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd7, 20'd5);
        build_frame(40, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd7, 20'd6);
        build_frame(36, 16'h0800, 8'h45, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd7, 20'd7);
        build_frame(42, 16'h0800, 8'h45, 16'h0, PROTO_UDP);
        send_frame(1'b1, 32'd8, 20'd8);
        build_frame(36, 16'h0800, 8'h45, 16'h0, PROTO_UDP);
        send_frame(1'b1, 32'd8, 20'd9);
        // capture ends with the IP header: no layer-4 fields
        build_frame(38, 16'h0800, 8'h46, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd8, 20'd10);
        // first fragment and fragment with offset
        build_frame(54, 16'h0800, 8'h45, 16'h2000, PROTO_TCP);
        send_frame(1'b1, 32'd9, 20'd11);
        build_frame(54, 16'h0800, 8'h45, 16'h00B9, PROTO_UDP);
        send_frame(1'b1, 32'd9, 20'd12);
        // small IHL, large IHL, and bytes past the header store
        build_frame(54, 16'h0800, 8'h43, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd10, 20'd13);
        build_frame(120, 16'h0800, 8'h4F, 16'h0, PROTO_TCP);
        send_frame(1'b1, 32'd10, 20'd14);
        build_frame(100, 16'h0800, 8'h4F, 16'h0, PROTO_ICMP);
        send_frame(1'b1, 32'd10, 20'd15);
        // frame without a start mark keeps the previous stamp
        build_frame(42, 16'h0800, 8'h45, 16'h0, PROTO_UDP);
        send_frame(1'b0, 32'hDEADBEEF, 20'd16);
    endtask

    initial begin
        int phase_frames;
        int phase_target;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tuser      = '0;
        calm         = 1'b0;
        squeeze      = 1'b0;
        bytes_sent   = 0;
        frames_sent  = 0;
        w_begin_sec  = '0;
        w_begin_usec = '0;
        w_end_sec    = '0;
        w_end_usec   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: configure(32'd0, 20'd0, 32'd0, 20'd0, 1'b0, 1'b0, 1'b0);
                1: configure(32'd0, 20'd0, 32'd0, 20'd0, 1'b1, 1'b0, 1'b1);
                2: configure(32'd1000, 20'd500000, 32'd1002, 20'd0, 1'b0, 1'b1, 1'b1);
                3: configure(32'd0, 20'd0, 32'hFFFFFFFF, 20'd999999, 1'b1, 1'b1, 1'b0);
                default: configure(32'hFFFFFFFF, 20'd999999, 32'hFFFFFFFF, 20'd999999,
                                   1'b0, 1'b1, 1'b0);
            endcase
            if (phase == 0) begin
                directed_frames();
            end
            // hold the sink off while one-byte frames pile up behind it
            if (phase == 1) begin
                squeeze = 1'b1;
                for (int i = 0; i < 40; i++) begin
                    build_frame(1, 16'h0, 8'h0, 16'h0, 8'h0);
                    send_frame(1'b1, $urandom, $urandom_range(999999));
                end
                squeeze = 1'b0;
            end
            // no idling on either side in this phase
            calm = (phase == 2);
            phase_target = (phase == 0) ? 0 : ((phase == 2) ? 4 : 2);
            phase_frames = 0;
            while (phase_frames < phase_target) begin
                random_frame();
                phase_frames++;
            end
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (20) @(posedge aclk);

        $display("sent %0d bytes in %0d frames over five register settings", bytes_sent,
                 frames_sent);
        $display("checked %0d flow records, %0d field mismatches", records_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pfhe_pkg.sv
hw/rtl/pfhe_front.sv
hw/rtl/pfhe_queue.sv
hw/rtl/pfhe_back.sv
hw/rtl/ipv4_packet_flow_header_extractor_unit.sv
tb/flow_record_checker.sv
tb/tb_ipv4_packet_flow_header_extractor_unit.sv
